@@ rtl/core/rc4_pkg.sv @@
package rc4_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PERM_DEPTH = 256;

    // codes carried in s_axis tuser
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_FILL,
        DP_KEY,
        DP_DATA_I,
        DP_DATA_J,
        DP_DATA_SW,
        DP_DATA_KS,
        DP_KS_RD,
        DP_KS_ACC,
        DP_KS_SW1,
        DP_KS_SW2
    } t_dp_op;

    typedef struct packed {
        logic n_max;
        logic can_take;
    } t_dp_stat;

endpackage

@@ rtl/core/rc4_stream_cipher.sv @@
// rc4 stream cipher engine. after reset the permutation memory is loaded with the
// identity in a pass during which no request is taken. key requests (tuser low)
// are stored; up to KEY_DEPTH bytes are kept, later ones are dropped. the key
// request with tlast high runs the key schedule: an identity load and then 256
// steps of a read, an accumulate read and the swap write pair, bounded by the
// single read and single write port of the permutation memory.
// each data request (tuser high) runs as two dependent reads, the swap write pair and
// the keystream read on that same memory, and returns one byte xored with the
// keystream, with tlast copied through. key bytes sent between data requests are only
// stored until the next final key byte.
module rc4_stream_cipher #(
    parameter int unsigned KEY_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] value
    input  logic       i_s_axis_tuser,   // [0] operation
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] data_out
    output logic       o_m_axis_tlast
);
    import rc4_pkg::*;

    t_dp_op   dp_cmd;
    t_dp_stat dp_stat;

    rc4_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tuser),
        .i_last  (i_s_axis_tlast),
        .i_stat  (dp_stat),
        .o_ready (o_s_axis_tready),
        .o_cmd   (dp_cmd)
    );

    rc4_datapath #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_value     (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (dp_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

    a_data_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd == DP_DATA_I |=> dp_cmd == DP_DATA_J)
        else $error("data request did not advance to the j read");

    a_data_sw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd == DP_DATA_J |=> dp_cmd == DP_DATA_SW ##1 dp_cmd == DP_DATA_KS)
        else $error("data request sequence broken");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (dp_cmd == DP_NONE || dp_cmd == DP_KEY || dp_cmd == DP_DATA_I))
        else $error("request taken while datapath busy");

    a_ks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd == DP_DATA_KS |=> !o_s_axis_tready || !o_m_axis_tvalid || i_m_axis_tready
            || dp_cmd == DP_NONE)
        else $error("keystream result lost");

endmodule

@@ rtl/core/rc4_ctrl.sv @@
module rc4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_op,
    input  logic              i_last,
    input  rc4_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output rc4_pkg::t_dp_op   o_cmd
);
    import rc4_pkg::*;

    typedef enum logic [9:0] {
        S_INIT = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_FILL = 10'b00_0000_0100,
        S_DJ   = 10'b00_0000_1000,
        S_DSW  = 10'b00_0001_0000,
        S_DKS  = 10'b00_0010_0000,
        S_KRD  = 10'b00_0100_0000,
        S_KACC = 10'b00_1000_0000,
        S_KSW1 = 10'b01_0000_0000,
        S_KSW2 = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = DP_NONE;
        o_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd = DP_FILL;
                if (i_stat.n_max) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = i_stat.can_take;
                if (i_valid && i_stat.can_take) begin
                    if (i_op == OP_DATA) begin
                        o_cmd   = DP_DATA_I;
                        n_state = S_DJ;
                    end else begin
                        o_cmd = DP_KEY;
                        if (i_last) begin
                            n_state = S_FILL;
                        end
                    end
                end
            end
            S_FILL: begin
                o_cmd = DP_FILL;
                if (i_stat.n_max) begin
                    n_state = S_KRD;
                end
            end
            S_DJ: begin
                o_cmd   = DP_DATA_J;
                n_state = S_DSW;
            end
            S_DSW: begin
                o_cmd   = DP_DATA_SW;
                n_state = S_DKS;
            end
            S_DKS: begin
                o_cmd   = DP_DATA_KS;
                n_state = S_IDLE;
            end
            S_KRD: begin
                o_cmd   = DP_KS_RD;
                n_state = S_KACC;
            end
            S_KACC: begin
                o_cmd   = DP_KS_ACC;
                n_state = S_KSW1;
            end
            S_KSW1: begin
                o_cmd   = DP_KS_SW1;
                n_state = S_KSW2;
            end
            S_KSW2: begin
                o_cmd   = DP_KS_SW2;
                n_state = i_stat.n_max ? S_IDLE : S_KRD;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

@@ rtl/core/rc4_datapath.sv @@
module rc4_datapath #(
    parameter int unsigned KEY_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4_pkg::t_dp_op   i_cmd,
    input  logic [7:0]        i_value,
    input  logic              i_last,
    input  logic              i_out_ready,
    output rc4_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output logic [7:0]        o_out_data,
    output logic              o_out_last
);
    import rc4_pkg::*;

    localparam int unsigned KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int unsigned CW = $clog2(KEY_DEPTH + 1);
    localparam int unsigned CX = CW + 1;

    logic [BYTE_W-1:0] r_perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] r_key_mem  [KEY_DEPTH];

    logic [BYTE_W-1:0] r_prd;
    logic [BYTE_W-1:0] r_krd;

    logic [BYTE_W-1:0] r_i;
    logic [BYTE_W-1:0] r_j;
    logic [BYTE_W-1:0] r_n;
    logic [BYTE_W-1:0] r_acc;
    logic [KW-1:0]     r_kpos;
    logic [CW-1:0]     r_kcnt;
    logic [BYTE_W-1:0] r_val;
    logic              r_last;
    logic [BYTE_W-1:0] r_si;
    logic [BYTE_W-1:0] r_sj;
    logic              r_t_i;
    logic              r_t_j;
    logic [BYTE_W-1:0] r_ks;
    logic              r_ks_last;
    logic              r_pend;
    logic              r_m_valid;
    logic [BYTE_W-1:0] r_m_data;
    logic              r_m_last;

    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] acc_sum;
    logic [BYTE_W-1:0] j_sum;
    logic [BYTE_W-1:0] t_sum;
    logic [BYTE_W-1:0] ks;
    logic              key_full;
    logic [CX-1:0]     kpos_inc;
    logic              out_move;
    logic              n_max;

    assign acc_sum  = r_acc + r_krd + r_prd;
    assign j_sum    = r_j + r_prd;
    assign t_sum    = r_si + r_prd;
    // entries of the swap in progress are not yet visible on the read port
    assign ks       = r_t_i ? r_sj : (r_t_j ? r_si : r_prd);
    assign key_full = (r_kcnt == CW'(KEY_DEPTH));
    assign kpos_inc = CX'(r_kpos) + CX'(1);
    assign out_move = r_pend && (!r_m_valid || i_out_ready);
    assign n_max    = (r_n == BYTE_W'(PERM_DEPTH - 1));

    assign o_stat.n_max    = n_max;
    assign o_stat.can_take = !r_pend || !r_m_valid || i_out_ready;
    assign o_out_valid     = r_m_valid;
    assign o_out_data      = r_m_data;
    assign o_out_last      = r_m_last;

    always_comb begin
        rd_addr = r_n;
        wr_en   = 1'b0;
        wr_addr = r_n;
        wr_data = r_n;
        case (i_cmd)
            DP_FILL: begin
                wr_en = 1'b1;
            end
            DP_DATA_I: begin
                rd_addr = r_i + BYTE_W'(1);
            end
            DP_DATA_J: begin
                rd_addr = j_sum;
            end
            DP_DATA_SW: begin
                rd_addr = t_sum;
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_prd;
            end
            DP_DATA_KS: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_si;
            end
            DP_KS_ACC: begin
                rd_addr = acc_sum;
            end
            DP_KS_SW1: begin
                wr_en   = 1'b1;
                wr_addr = r_n;
                wr_data = r_prd;
            end
            DP_KS_SW2: begin
                wr_en   = 1'b1;
                wr_addr = r_acc;
                wr_data = r_si;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prd <= r_perm_mem[rd_addr];
        if (wr_en) begin
            r_perm_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_krd <= r_key_mem[r_kpos];
        if (i_cmd == DP_KEY && !key_full) begin
            r_key_mem[r_kcnt[KW-1:0]] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i       <= '0;
            r_j       <= '0;
            r_n       <= '0;
            r_kcnt    <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            case (i_cmd)
                DP_FILL: begin
                    r_n <= r_n + BYTE_W'(1);
                end
                DP_KEY: begin
                    if (!key_full) begin
                        r_kcnt <= r_kcnt + CW'(1);
                    end
                end
                DP_DATA_I: begin
                    r_i <= r_i + BYTE_W'(1);
                end
                DP_DATA_J: begin
                    r_j <= j_sum;
                end
                DP_KS_SW2: begin
                    r_n <= r_n + BYTE_W'(1);
                    if (n_max) begin
                        r_i    <= '0;
                        r_j    <= '0;
                        r_kcnt <= '0;
                    end
                end
                default: begin
                    r_n <= r_n;
                end
            endcase

            if (i_cmd == DP_DATA_KS) begin
                r_pend <= 1'b1;
            end else if (out_move) begin
                r_pend <= 1'b0;
            end

            if (out_move) begin
                r_m_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_KEY: begin
                if (i_last) begin
                    r_acc  <= '0;
                    r_kpos <= '0;
                end
            end
            DP_DATA_I: begin
                r_val  <= i_value;
                r_last <= i_last;
            end
            DP_DATA_J: begin
                r_si <= r_prd;
            end
            DP_DATA_SW: begin
                r_sj  <= r_prd;
                r_t_i <= (t_sum == r_i);
                r_t_j <= (t_sum == r_j);
            end
            DP_DATA_KS: begin
                r_ks      <= r_val ^ ks;
                r_ks_last <= r_last;
            end
            DP_KS_ACC: begin
                r_acc <= acc_sum;
                r_si  <= r_prd;
            end
            DP_KS_SW2: begin
                // key bytes are used cyclically over the stored length
                if (kpos_inc >= CX'(r_kcnt)) begin
                    r_kpos <= '0;
                end else begin
                    r_kpos <= kpos_inc[KW-1:0];
                end
            end
            default: begin
                r_val <= r_val;
            end
        endcase
        if (out_move) begin
            r_m_data <= r_ks;
            r_m_last <= r_ks_last;
        end
    end

endmodule

@@ sim/rc4_stream_cipher_tb.sv @@
module rc4_stream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4_pkg::*;

    localparam int unsigned KEY_DEPTH   = 256;
    localparam int          N_ITEMS     = 650;
    localparam int          STALL_LIMIT = 6000;
    localparam int          LONG_HOLD   = 400;
    localparam int          N_DIRECTED  = 20;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
        logic       last;
        logic       pinned;
        logic [7:0] pin_data;
        logic       pin_last;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_cipher_out;

    // pinned rows are read straight off the reset permutation
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{OP_DATA, 8'h00, 1'b0, 1'b1, 8'h02, 1'b0},  // data before any key
        '{OP_DATA, 8'hFF, 1'b1, 1'b1, 8'hFA, 1'b1},
        '{OP_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // one-byte key
        '{OP_DATA, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},
        '{OP_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_KEY,  8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_KEY,  8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'h0F, 1'b1, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_KEY,  8'h12, 1'b0, 1'b0, 8'h00, 1'b0},  // stored only, stream goes on
        '{OP_DATA, 8'h3C, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'hC3, 1'b1, 1'b0, 8'h00, 1'b0},
        '{OP_KEY,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},  // schedules key 12 ff
        '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DATA, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = OP_KEY;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;

    // expectation pinned to the request currently offered
    logic       pin_valid = 1'b0;
    logic [7:0] pin_data = 8'h00;
    logic       pin_last = 1'b0;

    int s_idle_pct = 34;
    int r_idle_pct = 77;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    // predictor state
    logic [7:0]  sbox [PERM_DEPTH];
    logic [7:0]  ptr_i;
    logic [7:0]  ptr_j;
    logic [7:0]  key_bytes [KEY_DEPTH];
    int unsigned key_len;
    int unsigned key_run;

    t_cipher_out expected_bytes [$];

    int errors        = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int keys_run      = 0;
    int longest_key   = 0;
    int quiet_cycles  = 0;

    rc4_stream_cipher #(
        .KEY_DEPTH(KEY_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    function automatic void reset_cipher_state();
        for (int n = 0; n < PERM_DEPTH; n++) begin
            sbox[n] = n[7:0];
        end
        for (int n = 0; n < KEY_DEPTH; n++) begin
            key_bytes[n] = 8'h00;
        end
        ptr_i   = 8'h00;
        ptr_j   = 8'h00;
        key_len = 0;
        key_run = 0;
    endfunction

    function automatic void schedule_key();
        int unsigned kpos;
        int unsigned klen;
        logic [7:0]  acc;
        logic [7:0]  tmp;
        klen = (key_len == 0) ? 1 : key_len;
        for (int n = 0; n < PERM_DEPTH; n++) begin
            sbox[n] = n[7:0];
        end
        acc  = 8'h00;
        kpos = 0;
        for (int n = 0; n < PERM_DEPTH; n++) begin
            acc = acc + ((kpos < key_len) ? key_bytes[kpos] : 8'h00) + sbox[n];
            tmp = sbox[n];
            sbox[n] = sbox[acc];
            sbox[acc] = tmp;
            kpos++;
            if (kpos >= klen) begin
                kpos = 0;
            end
        end
        ptr_i   = 8'h00;
        ptr_j   = 8'h00;
        key_len = 0;
    endfunction

    function automatic void collect_key_byte(input logic [7:0] kb, input logic last);
        key_run++;
        if (key_len < KEY_DEPTH) begin
            key_bytes[key_len] = kb;
            key_len++;
        end
        if (last) begin
            if (key_run > longest_key) begin
                longest_key = key_run;
            end
            key_run = 0;
            keys_run++;
            schedule_key();
        end
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] din);
        logic [7:0] tmp;
        logic [7:0] ks_idx;
        ptr_i = ptr_i + 8'd1;
        ptr_j = ptr_j + sbox[ptr_i];
        tmp = sbox[ptr_i];
        sbox[ptr_i] = sbox[ptr_j];
        sbox[ptr_j] = tmp;
        ks_idx = sbox[ptr_i] + sbox[ptr_j];
        return din ^ sbox[ks_idx];
    endfunction

    initial begin
        reset_cipher_state();
    end

    // requests in are predicted before results out are compared
    always @(posedge i_clk) begin
        t_cipher_out want;
        t_cipher_out got;
        if (rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                if (s_tuser == OP_DATA) begin
                    want.data = cipher_byte(s_tdata);
                    want.last = s_tlast;
                    if (pin_valid) begin
                        want.data = pin_data;
                        want.last = pin_last;
                    end
                    expected_bytes.push_back(want);
                end else begin
                    collect_key_byte(s_tdata, s_tlast);
                end
            end
            if (o_m_axis_tvalid && m_tready) begin
                got.data = o_m_axis_tdata;
                got.last = o_m_axis_tlast;
                if (expected_bytes.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result data=%02h last=%0b", got.data, got.last);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (got.data !== want.data || got.last !== want.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result %0d: expected data=%02h last=%0b, got data=%02h last=%0b",
                                     bytes_checked, want.data, want.last, got.data, got.last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", quiet_cycles);
            $display("rc4_stream_cipher_tb: errors");
            $finish;
        end
    end

    // receiver side, with its own long hold-off counter
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] val, input logic last,
                             input logic pinned, input logic [7:0] pdata, input logic plast);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= val;
        s_tlast   <= last;
        pin_valid <= pinned;
        pin_data  <= pdata;
        pin_last  <= plast;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_plain(input logic op, input logic [7:0] val, input logic last);
        send_item(op, val, last, 1'b0, 8'h00, 1'b0);
    endtask

    task automatic send_key(input int len);
        for (int k = 0; k < len; k++) begin
            send_plain(OP_KEY, 8'($urandom), k == len - 1);
        end
    endtask

    task automatic send_data(input int len, input bit random_last);
        for (int k = 0; k < len; k++) begin
            send_plain(OP_DATA, 8'($urandom),
                       random_last ? 1'($urandom) : (k == len - 1));
        end
    endtask

    initial begin
        int seq;
        int pick;
        int phase;
        seq   = 0;
        phase = 1;
        repeat (5) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].last,
                      DIRECTED[r].pinned, DIRECTED[r].pin_data, DIRECTED[r].pin_last);
        end

        while (items_sent < N_ITEMS) begin
            if (phase == 1 && items_sent >= N_ITEMS / 3) begin
                phase = 2;
                s_idle_pct = 77;
                r_idle_pct = 34;
            end else if (phase == 2 && items_sent >= 2 * N_ITEMS / 3) begin
                phase = 3;
                s_idle_pct = 0;
                r_idle_pct = 0;
                // receiver stalls long while the sender keeps pushing data
                hold_asked++;
                send_data(24, 1'b0);
            end
            pick = $urandom_range(99);
            if (seq == 6) begin
                // overfills the key store; the final byte is dropped too
                send_key(KEY_DEPTH + 2);
            end else if (pick < 80) begin
                send_key(($urandom_range(9) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16));
                send_data($urandom_range(1, 24), 1'b0);
            end else if (pick < 88) begin
                send_data($urandom_range(1, 12), 1'b1);
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 4)) send_plain(OP_KEY, 8'($urandom), 1'b0);
                send_data($urandom_range(1, 8), 1'b1);
            end else begin
                send_plain(1'($urandom), 8'($urandom), 1'($urandom));
            end
            seq++;
        end
        send_data(4, 1'b0);
        s_tvalid <= 1'b0;

        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (expected_bytes.size() != 0) begin
            errors++;
        end
        $display("%0d requests in, %0d cipher bytes checked, %0d keys scheduled",
                 items_sent, bytes_checked, keys_run);
        $display("longest key run %0d bytes, %0d mismatches", longest_key, errors);
        if (errors == 0) begin
            $display("rc4_stream_cipher_tb: clean");
        end else begin
            $display("rc4_stream_cipher_tb: errors");
        end
        $finish;
    end

endmodule

@@ rc4_stream_cipher.f @@
rtl/core/rc4_pkg.sv
rtl/core/rc4_ctrl.sv
rtl/core/rc4_datapath.sv
rtl/core/rc4_stream_cipher.sv
sim/rc4_stream_cipher_tb.sv
